### rtl/acs_pkg.sv
// acs_pkg: shared types and constants for the accelerated cursor stepper
// holds the configuration register layout, reset values and register indexes
// used by every module in rtl/, depends on nothing else
package acs_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam int TIME_W  = 32;
    localparam int DIR_W   = 2;
    localparam int STEP_W  = 6;
    localparam int LIMIT_W = 16;
    localparam int DIM_W   = 13;
    localparam int ZONE_W  = 8;
    localparam int POS_W   = 14;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_LIMIT = 3'd0,
        REG_IMAGE_WIDTH = 3'd1,
        REG_IMAGE_HEIGHT = 3'd2,
        REG_MIN_STEP = 3'd3,
        REG_MAX_STEP = 3'd4,
        REG_EDGE_ZONE = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] accel_time_limit;
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
        logic [STEP_W-1:0]  min_step;
        logic [STEP_W-1:0]  max_step;
        logic [ZONE_W-1:0]  edge_zone;
    } cfg_t;

    localparam logic [LIMIT_W-1:0] ACCEL_LIMIT_RST  = 16'd20;
    localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST = 13'd480;
    localparam logic [STEP_W-1:0]  MIN_STEP_RST     = 6'd4;
    localparam logic [STEP_W-1:0]  MAX_STEP_RST     = 6'd32;
    localparam logic [ZONE_W-1:0]  EDGE_ZONE_RST    = 8'd12;

endpackage

### rtl/accelerated_cursor_stepper.sv
// accelerated_cursor_stepper: top level, input register, step state, move logic, result register
// a press accepted into the input register is computed into the result register, which drives m_*
// throughput: one press per cycle while results are taken; the step state loop closes within the compute stage
// s_tready drops only while both registers are full and m_tready is low
// reset (aresetn low, synchronous): both stages empty, step history cleared, registers to defaults
// depends on acs_pkg, acs_cfg_regs, acs_step_gen and acs_edge_move
module accelerated_cursor_stepper #(
    parameter int COORD_BITS = acs_pkg::COORD_BITS_DEF,
    localparam int S_FIELDS_W = acs_pkg::TIME_W + 2 * acs_pkg::DIR_W + 2 * COORD_BITS,
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8,
    localparam int M_FIELDS_W = 2 * acs_pkg::POS_W + 1 + acs_pkg::STEP_W,
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // press_time, dir_x, dir_y, cur_x, cur_y, zero fill
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [S_DATA_W-1:0]                s_tdata,
    // new_x, new_y, inside_res, step_used, zero fill
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [M_DATA_W-1:0]                m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [acs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [acs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DX_LO = acs_pkg::TIME_W;
    localparam int DY_LO = DX_LO + acs_pkg::DIR_W;
    localparam int CX_LO = DY_LO + acs_pkg::DIR_W;
    localparam int CY_LO = CX_LO + COORD_BITS;

    acs_pkg::cfg_t cfg;

    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic [acs_pkg::TIME_W-1:0]    press_time_reg;
    logic [acs_pkg::DIR_W-1:0]     dir_x_reg;
    logic [acs_pkg::DIR_W-1:0]     dir_y_reg;
    logic [COORD_BITS-1:0]         cur_x_reg;
    logic [COORD_BITS-1:0]         cur_y_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [M_FIELDS_W-1:0]         out_data_reg;

    logic                          s_accept;
    logic                          advance;
    logic [acs_pkg::STEP_W-1:0]    step;
    logic [acs_pkg::POS_W-1:0]     new_x;
    logic [acs_pkg::POS_W-1:0]     new_y;
    logic                          inside_res;

    acs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    acs_step_gen u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (advance),
        .press_time (press_time_reg),
        .dir_x      (dir_x_reg),
        .dir_y      (dir_y_reg),
        .cfg        (cfg),
        .step       (step)
    );

    acs_edge_move #(
        .COORD_BITS (COORD_BITS)
    ) u_move (
        .cur_x      (cur_x_reg),
        .cur_y      (cur_y_reg),
        .dir_x      (dir_x_reg),
        .dir_y      (dir_y_reg),
        .step       (step),
        .cfg        (cfg),
        .new_x      (new_x),
        .new_y      (new_y),
        .inside_res (inside_res)
    );

    // compute stage moves on whenever the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-M_FIELDS_W){1'b0}}, out_data_reg};

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            press_time_reg <= s_tdata[acs_pkg::TIME_W-1:0];
            dir_x_reg      <= s_tdata[DX_LO +: acs_pkg::DIR_W];
            dir_y_reg      <= s_tdata[DY_LO +: acs_pkg::DIR_W];
            cur_x_reg      <= s_tdata[CX_LO +: COORD_BITS];
            cur_y_reg      <= s_tdata[CY_LO +: COORD_BITS];
        end
        if (advance) begin
            out_data_reg <= {step, inside_res, new_y, new_x};
        end
    end

endmodule

### rtl/acs_cfg_regs.sv
// acs_cfg_regs: configuration register file of the cursor stepper
// depends on acs_pkg for the register layout, indexes and reset values
module acs_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [acs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [acs_pkg::CFG_DATA_W-1:0]     cfg_data,
    output acs_pkg::cfg_t                      cfg
);

    acs_pkg::cfg_t cfg_reg;
    acs_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                acs_pkg::REG_ACCEL_LIMIT: begin
                    cfg_next.accel_time_limit = cfg_data;
                end
                acs_pkg::REG_IMAGE_WIDTH: begin
                    cfg_next.image_width = cfg_data[acs_pkg::DIM_W-1:0];
                end
                acs_pkg::REG_IMAGE_HEIGHT: begin
                    cfg_next.image_height = cfg_data[acs_pkg::DIM_W-1:0];
                end
                acs_pkg::REG_MIN_STEP: begin
                    cfg_next.min_step = cfg_data[acs_pkg::STEP_W-1:0];
                end
                acs_pkg::REG_MAX_STEP: begin
                    cfg_next.max_step = cfg_data[acs_pkg::STEP_W-1:0];
                end
                acs_pkg::REG_EDGE_ZONE: begin
                    cfg_next.edge_zone = cfg_data[acs_pkg::ZONE_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.accel_time_limit <= acs_pkg::ACCEL_LIMIT_RST;
            cfg_reg.image_width      <= acs_pkg::IMAGE_WIDTH_RST;
            cfg_reg.image_height     <= acs_pkg::IMAGE_HEIGHT_RST;
            cfg_reg.min_step         <= acs_pkg::MIN_STEP_RST;
            cfg_reg.max_step         <= acs_pkg::MAX_STEP_RST;
            cfg_reg.edge_zone        <= acs_pkg::EDGE_ZONE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/acs_step_gen.sv
// acs_step_gen: step size state and acceleration decision
// keeps last press time, direction and step; depends on acs_pkg
module acs_step_gen (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            fire,
    input  logic [acs_pkg::TIME_W-1:0]      press_time,
    input  logic [acs_pkg::DIR_W-1:0]       dir_x,
    input  logic [acs_pkg::DIR_W-1:0]       dir_y,
    input  acs_pkg::cfg_t                   cfg,
    output logic [acs_pkg::STEP_W-1:0]      step
);

    logic [acs_pkg::TIME_W-1:0] prev_time_reg;
    logic [acs_pkg::STEP_W-1:0] prev_step_reg;
    logic [acs_pkg::DIR_W-1:0]  prev_dir_x_reg;
    logic [acs_pkg::DIR_W-1:0]  prev_dir_y_reg;

    logic [acs_pkg::TIME_W-1:0] gap;
    logic [acs_pkg::STEP_W:0]   doubled;
    logic                       restart;

    always_comb begin
        // wrapping tick difference
        gap     = press_time - prev_time_reg;
        restart = (gap > {{(acs_pkg::TIME_W-acs_pkg::LIMIT_W){1'b0}}, cfg.accel_time_limit})
                  || (dir_x != prev_dir_x_reg) || (dir_y != prev_dir_y_reg);
        doubled = {prev_step_reg, 1'b0};
        if (restart) begin
            step = cfg.min_step;
        end else if (doubled < {1'b0, cfg.max_step}) begin
            step = doubled[acs_pkg::STEP_W-1:0];
        end else begin
            step = cfg.max_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_time_reg  <= '0;
            prev_step_reg  <= '0;
            prev_dir_x_reg <= '0;
            prev_dir_y_reg <= '0;
        end else if (fire) begin
            prev_time_reg  <= press_time;
            prev_step_reg  <= step;
            prev_dir_x_reg <= dir_x;
            prev_dir_y_reg <= dir_y;
        end
    end

endmodule

### rtl/acs_edge_move.sv
// acs_edge_move: moves the cursor by direction times step and applies edge slow-down
// purely combinational, sits between the input and result registers; depends on acs_pkg
module acs_edge_move #(
    parameter int COORD_BITS = acs_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0]           cur_x,
    input  logic [COORD_BITS-1:0]           cur_y,
    input  logic [acs_pkg::DIR_W-1:0]       dir_x,
    input  logic [acs_pkg::DIR_W-1:0]       dir_y,
    input  logic [acs_pkg::STEP_W-1:0]      step,
    input  acs_pkg::cfg_t                   cfg,
    output logic [acs_pkg::POS_W-1:0]       new_x,
    output logic [acs_pkg::POS_W-1:0]       new_y,
    output logic                            inside_res
);

    // room for the widest coordinate or image size plus move and sign
    localparam int CALC_W = ((COORD_BITS > acs_pkg::DIM_W) ? COORD_BITS : acs_pkg::DIM_W) + 3;

    logic signed [CALC_W-1:0] ox, oy, mx, my, x, y;
    logic signed [CALC_W-1:0] sdx, sdy, sstep;
    logic signed [CALC_W-1:0] zone, mn, w, h;
    logic signed [CALC_W-1:0] lo_x, lo_y, hi_x, hi_y;

    always_comb begin
        ox    = $signed({{(CALC_W-COORD_BITS){1'b0}}, cur_x});
        oy    = $signed({{(CALC_W-COORD_BITS){1'b0}}, cur_y});
        sdx   = $signed({{(CALC_W-acs_pkg::DIR_W){dir_x[acs_pkg::DIR_W-1]}}, dir_x});
        sdy   = $signed({{(CALC_W-acs_pkg::DIR_W){dir_y[acs_pkg::DIR_W-1]}}, dir_y});
        sstep = $signed({{(CALC_W-acs_pkg::STEP_W){1'b0}}, step});
        zone  = $signed({{(CALC_W-acs_pkg::ZONE_W){1'b0}}, cfg.edge_zone});
        mn    = $signed({{(CALC_W-acs_pkg::STEP_W){1'b0}}, cfg.min_step});
        w     = $signed({{(CALC_W-acs_pkg::DIM_W){1'b0}}, cfg.image_width});
        h     = $signed({{(CALC_W-acs_pkg::DIM_W){1'b0}}, cfg.image_height});

        mx = ox + sdx * sstep;
        my = oy + sdy * sstep;

        lo_x = ox - mn;
        lo_y = oy - mn;
        hi_x = ox + mn;
        hi_y = oy + mn;

        x = mx;
        y = my;
        // first matching edge wins: top, bottom, left, right
        if ((my < zone) && (my < oy)) begin
            y = (zone < lo_y) ? zone : lo_y;
        end else if ((h - my < zone) && (my > oy)) begin
            y = ((h - zone) > hi_y) ? (h - zone) : hi_y;
        end else if ((mx < zone) && (mx < ox)) begin
            x = (zone < lo_x) ? zone : lo_x;
        end else if ((w - mx < zone) && (mx > ox)) begin
            x = ((w - zone) > hi_x) ? (w - zone) : hi_x;
        end

        inside_res = !((y < 0) || (y >= h) || (x < 0) || (x >= w));
        new_x      = x[acs_pkg::POS_W-1:0];
        new_y      = y[acs_pkg::POS_W-1:0];
    end

endmodule

### tb/tb_accelerated_cursor_stepper.sv
// tb_accelerated_cursor_stepper: self-checking bench for the accelerated cursor stepper
// drives key presses and register writes, predicts each move and compares every result word
// depends on acs_pkg and the rtl under rtl/
module tb_accelerated_cursor_stepper;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int S_W = 64;
    localparam int M_W = 40;
    localparam int unsigned CYCLE_LIMIT = 400000;

    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_POS  = 2'b01;
    localparam logic [1:0] DIR_NEG2 = 2'b10;
    localparam logic [1:0] DIR_NEG  = 2'b11;

    typedef struct packed {
        logic [31:0] press_time;
        logic [1:0]  dir_x;
        logic [1:0]  dir_y;
        logic [11:0] cur_x;
        logic [11:0] cur_y;
    } press_t;

    typedef struct packed {
        logic [13:0] new_x;
        logic [13:0] new_y;
        logic        in_image;
        logic [5:0]  step_used;
    } move_t;

    typedef struct {
        logic [15:0] accel_limit;
        logic [15:0] img_w;
        logic [15:0] img_h;
        logic [15:0] step_min;
        logic [15:0] step_max;
        logic [15:0] zone;
    } regs_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    acs_pkg::cfg_index_t cfg_index = acs_pkg::REG_ACCEL_LIMIT;
    logic [acs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of the registers
    logic [acs_pkg::LIMIT_W-1:0] lim_q;
    logic [acs_pkg::DIM_W-1:0]   img_w_q;
    logic [acs_pkg::DIM_W-1:0]   img_h_q;
    logic [acs_pkg::STEP_W-1:0]  step_min_q;
    logic [acs_pkg::STEP_W-1:0]  step_max_q;
    logic [acs_pkg::ZONE_W-1:0]  zone_q;
    // predictor copy of the press history
    logic [31:0] last_time;
    logic [5:0]  last_step;
    logic [1:0]  last_dx;
    logic [1:0]  last_dy;

    move_t move_q[$];
    int fails = 0;
    int presses_sent = 0;
    int moves_checked = 0;
    int moves_out = 0;
    int reg_writes = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int unsigned cycle_count = 0;

    // generator state for streaks of presses
    logic [31:0] tick = '0;
    int streak_left = 0;
    logic [1:0] streak_dx, streak_dy;
    logic [11:0] pos_x, pos_y;

    accelerated_cursor_stepper dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // press_time, dir_x, dir_y, cur_x, cur_y, zero fill
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // new_x, new_y, inside_res, step_used, zero fill
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_accelerated_cursor_stepper: FAIL");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(negedge aclk) begin : recv_stall
        int hold_left;
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_moves
        move_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.new_x     = m_tdata[13:0];
            got.new_y     = m_tdata[27:14];
            got.in_image  = m_tdata[28];
            got.step_used = m_tdata[34:29];
            if (move_q.size() == 0) begin
                $error("result word with no press waiting: %h", m_tdata);
                fails++;
            end else begin
                want = move_q.pop_front();
                moves_checked++;
                if (got.new_x !== want.new_x) begin
                    $error("new_x: expected %0d, got %0d", $signed(want.new_x), $signed(got.new_x));
                    fails++;
                end
                if (got.new_y !== want.new_y) begin
                    $error("new_y: expected %0d, got %0d", $signed(want.new_y), $signed(got.new_y));
                    fails++;
                end
                if (got.in_image !== want.in_image) begin
                    $error("inside_res: expected %0d, got %0d", want.in_image, got.in_image);
                    fails++;
                end
                if (got.step_used !== want.step_used) begin
                    $error("step_used: expected %0d, got %0d", want.step_used, got.step_used);
                    fails++;
                end
            end
        end
    end

    // works out the move for one accepted press and advances the history
    function automatic move_t predict_move(press_t p);
        move_t r;
        logic [31:0] gap;
        logic [6:0] dbl;
        logic [5:0] stp;
        int ox, oy, x, y, zn, mn, w, h;
        gap = p.press_time - last_time;
        if (gap > lim_q || p.dir_x != last_dx || p.dir_y != last_dy) begin
            stp = step_min_q;
        end else begin
            dbl = {last_step, 1'b0};
            stp = (dbl < {1'b0, step_max_q}) ? dbl[5:0] : step_max_q;
        end
        last_step = stp;
        last_time = p.press_time;
        last_dx = p.dir_x;
        last_dy = p.dir_y;
        ox = int'(p.cur_x);
        oy = int'(p.cur_y);
        zn = int'(zone_q);
        mn = int'(step_min_q);
        w  = int'(img_w_q);
        h  = int'(img_h_q);
        x = ox + int'($signed(p.dir_x)) * int'(stp);
        y = oy + int'($signed(p.dir_y)) * int'(stp);
        // only the first edge rule that matches is applied
        if (y < zn && y < oy)
            y = (zn < oy - mn) ? zn : oy - mn;
        else if (h - y < zn && y > oy)
            y = (h - zn > oy + mn) ? h - zn : oy + mn;
        else if (x < zn && x < ox)
            x = (zn < ox - mn) ? zn : ox - mn;
        else if (w - x < zn && x > ox)
            x = (w - zn > ox + mn) ? w - zn : ox + mn;
        r.new_x = x[13:0];
        r.new_y = y[13:0];
        r.in_image = !(y < 0 || y >= h || x < 0 || x >= w);
        r.step_used = stp;
        return r;
    endfunction

    // called just after a falling edge, returns just after one
    task automatic send_press(input press_t p, output move_t want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, p.cur_y, p.cur_x, p.dir_y, p.dir_x, p.press_time};
        do @(posedge aclk); while (!s_tready);
        want = predict_move(p);
        move_q.push_back(want);
        presses_sent++;
        if (!want.in_image)
            moves_out++;
        @(negedge aclk);
    endtask

    task automatic press(logic [31:0] t, logic [1:0] dx, logic [1:0] dy,
                         logic [11:0] cx, logic [11:0] cy);
        press_t p;
        move_t want;
        p.press_time = t;
        p.dir_x = dx;
        p.dir_y = dy;
        p.cur_x = cx;
        p.cur_y = cy;
        send_press(p, want);
    endtask

    task automatic drain_moves();
        s_tvalid <= 1'b0;
        while (move_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(acs_pkg::cfg_index_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            acs_pkg::REG_ACCEL_LIMIT:  lim_q      = val[acs_pkg::LIMIT_W-1:0];
            acs_pkg::REG_IMAGE_WIDTH:  img_w_q    = val[acs_pkg::DIM_W-1:0];
            acs_pkg::REG_IMAGE_HEIGHT: img_h_q    = val[acs_pkg::DIM_W-1:0];
            acs_pkg::REG_MIN_STEP:     step_min_q = val[acs_pkg::STEP_W-1:0];
            acs_pkg::REG_MAX_STEP:     step_max_q = val[acs_pkg::STEP_W-1:0];
            acs_pkg::REG_EDGE_ZONE:    zone_q     = val[acs_pkg::ZONE_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
    endtask

    // only while the block is idle
    task automatic program_regs(regs_t r);
        drain_moves();
        write_reg(acs_pkg::REG_ACCEL_LIMIT, r.accel_limit);
        write_reg(acs_pkg::REG_IMAGE_WIDTH, r.img_w);
        write_reg(acs_pkg::REG_IMAGE_HEIGHT, r.img_h);
        write_reg(acs_pkg::REG_MIN_STEP, r.step_min);
        write_reg(acs_pkg::REG_MAX_STEP, r.step_max);
        write_reg(acs_pkg::REG_EDGE_ZONE, r.zone);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [1:0] pick_dir();
        int r;
        r = $urandom_range(0, 19);
        if (r < 6)
            return DIR_NEG;
        else if (r < 12)
            return DIR_NONE;
        else if (r < 18)
            return DIR_POS;
        return DIR_NEG2;
    endfunction

    // coordinate biased towards the edges of an image of the given extent
    function automatic logic [11:0] edge_biased(int extent);
        int span, v;
        span = (extent < 1 || extent > 4096) ? 4096 : extent;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, int'(zone_q) + 8);
            1: v = span - 1 - int'($urandom_range(0, int'(zone_q) + 8));
            default: v = $urandom_range(0, span - 1);
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[11:0];
    endfunction

    function automatic regs_t random_regs();
        regs_t r;
        r.accel_limit = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                        : $urandom_range(0, 64));
        r.img_w = 16'(($urandom_range(0, 4) == 0) ? $urandom_range(1, 64)
                                                  : $urandom_range(1, 4096));
        r.img_h = 16'(($urandom_range(0, 4) == 0) ? $urandom_range(1, 64)
                                                  : $urandom_range(1, 4096));
        r.step_min = 16'($urandom_range(1, 16));
        r.step_max = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 63)
                                                     : $urandom_range(r.step_min, 63));
        r.zone = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 40));
        return r;
    endfunction

    // mostly streaks in one direction with short gaps, plus some raw noise
    task automatic run_presses(int n);
        press_t p;
        move_t want;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                p.press_time = $urandom;
                p.dir_x = 2'($urandom);
                p.dir_y = 2'($urandom);
                p.cur_x = 12'($urandom);
                p.cur_y = 12'($urandom);
                streak_left = 0;
            end else begin
                if (streak_left == 0) begin
                    streak_left = $urandom_range(1, 10);
                    streak_dx = pick_dir();
                    streak_dy = pick_dir();
                    pos_x = edge_biased(int'(img_w_q));
                    pos_y = edge_biased(int'(img_h_q));
                    tick = tick + $urandom;
                end else if ($urandom_range(0, 9) == 0) begin
                    tick = tick + lim_q + 1 + $urandom_range(0, 1000);
                end else begin
                    tick = tick + $urandom_range(0, lim_q);
                end
                streak_left--;
                p.press_time = tick;
                p.dir_x = streak_dx;
                p.dir_y = streak_dy;
                p.cur_x = pos_x;
                p.cur_y = pos_y;
            end
            send_press(p, want);
            if (want.in_image) begin
                pos_x = want.new_x[11:0];
                pos_y = want.new_y[11:0];
            end else begin
                pos_x = edge_biased(int'(img_w_q));
                pos_y = edge_biased(int'(img_h_q));
            end
        end
    endtask

    // runs at the reset register values
    task automatic test_directed();
        // history is zero after reset, so an early press doubles a zero step
        press(32'd5, DIR_NONE, DIR_NONE, 12'd100, 12'd100);
        press(32'd10, DIR_NONE, DIR_NONE, 12'd100, 12'd100);
        // acceleration up to the cap
        press(32'd12, DIR_POS, DIR_NONE, 12'd100, 12'd100);
        press(32'd20, DIR_POS, DIR_NONE, 12'd104, 12'd100);
        press(32'd30, DIR_POS, DIR_NONE, 12'd112, 12'd100);
        press(32'd40, DIR_POS, DIR_NONE, 12'd128, 12'd100);
        press(32'd50, DIR_POS, DIR_NONE, 12'd160, 12'd100);
        // one tick too late, then exactly on the limit
        press(32'd71, DIR_POS, DIR_NONE, 12'd192, 12'd100);
        press(32'd91, DIR_POS, DIR_NONE, 12'd196, 12'd100);
        // the spare direction pattern multiplies by minus two
        press(32'd92, DIR_NEG2, DIR_NONE, 12'd300, 12'd200);
        press(32'd93, DIR_NEG2, DIR_NEG2, 12'd300, 12'd300);
        press(32'd94, DIR_NEG2, DIR_NEG2, 12'd292, 12'd292);
        // top, bottom, left and right slow-downs, the last two falling out
        press(32'd200, DIR_NONE, DIR_NEG, 12'd200, 12'd10);
        press(32'd300, DIR_NONE, DIR_POS, 12'd200, 12'd475);
        press(32'd400, DIR_NEG, DIR_NONE, 12'd3, 12'd200);
        press(32'd500, DIR_POS, DIR_NONE, 12'd639, 12'd200);
        // field extremes and a gap that wraps round zero
        press(32'hFFFF_FFFF, DIR_POS, DIR_POS, 12'd4095, 12'd4095);
        press(32'h0000_0003, DIR_POS, DIR_POS, 12'd0, 12'd0);
        press(32'h0000_0004, DIR_NEG, DIR_NEG, 12'd0, 12'd0);
        press(32'h0000_0005, DIR_NEG, DIR_NEG, 12'd4095, 12'd0);
        press(32'hFFFF_0000, DIR_POS, DIR_NEG2, 12'd2048, 12'd4095);
        press(32'hFFFF_0001, DIR_NONE, DIR_NONE, 12'd5, 12'd479);
        press(32'h8000_0000, DIR_NEG2, DIR_POS, 12'd4095, 12'd0);
        drain_moves();
    endtask

    task automatic test_register_extremes();
        regs_t sets[6];
        sets[0] = '{16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0};
        sets[1] = '{16'd65535, 16'd4096, 16'd4096, 16'd63, 16'd63, 16'd255};
        // beyond the documented ranges: used as written, masked to width
        sets[2] = '{16'hFFFF, 16'd8191, 16'd0, 16'd63, 16'd1, 16'hFFFF};
        sets[3] = '{16'd100, 16'd0, 16'd4096, 16'd0, 16'd63, 16'd200};
        sets[4] = '{16'd1, 16'hFFFF, 16'h0000, 16'hFFC5, 16'hFFE3, 16'hFF00};
        sets[5] = '{16'd20, 16'd640, 16'd480, 16'd4, 16'd32, 16'd12};
        foreach (sets[i]) begin
            program_regs(sets[i]);
            run_presses(30);
        end
    endtask

    task automatic test_backpressure();
        hold_req = 300;
        run_presses(40);
        drain_moves();
    endtask

    task automatic test_random_traffic(int n, int s_idle, int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int done = 0; done < n; done += 150) begin
            program_regs(random_regs());
            run_presses(150);
        end
    endtask

    initial begin
        lim_q      = acs_pkg::ACCEL_LIMIT_RST;
        img_w_q    = acs_pkg::IMAGE_WIDTH_RST;
        img_h_q    = acs_pkg::IMAGE_HEIGHT_RST;
        step_min_q = acs_pkg::MIN_STEP_RST;
        step_max_q = acs_pkg::MAX_STEP_RST;
        zone_q     = acs_pkg::EDGE_ZONE_RST;
        last_time  = '0;
        last_step  = '0;
        last_dx    = '0;
        last_dy    = '0;
        send_idle_pct = 23;
        recv_idle_pct = 62;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_register_extremes();
        test_backpressure();
        test_random_traffic(450, 23, 62);
        test_random_traffic(450, 62, 23);
        test_random_traffic(450, 0, 0);

        drain_moves();
        repeat (10) @(posedge aclk);
        $display("run covered %0d presses and %0d register writes over several settings;",
                 presses_sent, reg_writes);
        $display("%0d moves checked, %0d of them off the image", moves_checked, moves_out);
        if (fails == 0)
            $display("tb_accelerated_cursor_stepper: PASS");
        else
            $display("tb_accelerated_cursor_stepper: FAIL");
        $finish;
    end

endmodule

### files.f
rtl/acs_pkg.sv
rtl/acs_cfg_regs.sv
rtl/acs_step_gen.sv
rtl/acs_edge_move.sv
rtl/accelerated_cursor_stepper.sv
tb/tb_accelerated_cursor_stepper.sv
